@@ rtl/touch_to_relative_mouse_defines.svh @@
// ----------------------------------------------------------------------------
// touch_to_relative_mouse_defines
// assertion macros shared by the touch to mouse block
// ----------------------------------------------------------------------------
`ifndef TOUCH_TO_RELATIVE_MOUSE_DEFINES_SVH
`define TOUCH_TO_RELATIVE_MOUSE_DEFINES_SVH

// checked only outside reset
`define TTRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TTRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ttrm_pkg.sv @@
// ----------------------------------------------------------------------------
// ttrm_pkg
// types and constants of the touch to relative mouse block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttrm_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_COUNT_MIN  = 3'd0,
    CFG_HOLD_MOTION_MAX = 3'd1,
    CFG_TAP_MOTION_MAX  = 3'd2,
    CFG_TAP_COUNT_MAX   = 3'd3
  } cfg_idx_t;

  localparam logic [15:0] HoldCountMinRst  = 16'd150;
  localparam logic [15:0] HoldMotionMaxRst = 16'd60;
  localparam logic [15:0] TapMotionMaxRst  = 16'd20;
  localparam logic [15:0] TapCountMaxRst   = 16'd100;

  localparam logic [15:0] Sat16     = 16'hFFFF;
  localparam logic [7:0]  LeftKeys  = 8'h69;
  localparam logic [7:0]  RightKeys = 8'h96;

  typedef struct packed {
    logic [15:0] hold_count_min;
    logic [15:0] hold_motion_max;
    logic [15:0] tap_motion_max;
    logic [15:0] tap_count_max;
  } cfg_t;

  typedef struct packed {
    logic       touch_down;
    logic [7:0] touch_x;
    logic [7:0] touch_y;
    logic       speed_fast;
    logic       speed_slow;
    logic [7:0] button_keys;
  } sample_t;

  typedef struct packed {
    logic [1:0]        mouse_buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } report_t;

endpackage

@@ rtl/ttrm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ttrm_cfg_regs
// threshold registers written through the plain write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttrm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ttrm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                   cfg_data,
  output ttrm_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_count_min  <= ttrm_pkg::HoldCountMinRst;
      cfg.hold_motion_max <= ttrm_pkg::HoldMotionMaxRst;
      cfg.tap_motion_max  <= ttrm_pkg::TapMotionMaxRst;
      cfg.tap_count_max   <= ttrm_pkg::TapCountMaxRst;
    end else if (cfg_we) begin
      case (cfg_index)
        ttrm_pkg::CFG_HOLD_COUNT_MIN:  cfg.hold_count_min  <= cfg_data;
        ttrm_pkg::CFG_HOLD_MOTION_MAX: cfg.hold_motion_max <= cfg_data;
        ttrm_pkg::CFG_TAP_MOTION_MAX:  cfg.tap_motion_max  <= cfg_data;
        ttrm_pkg::CFG_TAP_COUNT_MAX:   cfg.tap_count_max   <= cfg_data;
        default: ; // unused index, ignored
      endcase
    end
  end

endmodule

@@ rtl/ttrm_track.sv @@
// ----------------------------------------------------------------------------
// ttrm_track
// touch tracking state and the report logic for one sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttrm_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ttrm_pkg::cfg_t    cfg,
  input  ttrm_pkg::sample_t smp,
  output ttrm_pkg::report_t rpt
);

  logic        was_touching, was_touching_next;
  logic [7:0]  prev_x, prev_x_next;
  logic [7:0]  prev_y, prev_y_next;
  logic [15:0] sample_count, sample_count_next;
  logic [15:0] motion_sum, motion_sum_next;
  logic        hold_latched, hold_latched_next;

  logic        moving;
  logic [7:0]  dx, dy, sx, sy, ax, ay;
  logic [17:0] sum_wide;
  logic [15:0] sum_sat;
  logic        hold_now;
  logic        tap;

  function automatic logic [7:0] scale8(input logic [7:0] d, input logic fast,
                                        input logic slow);
    logic [7:0] d2;
    d2 = {d[6:0], 1'b0};
    if (slow) return d;
    else if (fast) return d2 + d;
    else return d2;
  endfunction

  always_comb begin
    moving   = smp.touch_down & was_touching;
    dx       = smp.touch_x - prev_x;
    dy       = smp.touch_y - prev_y;
    ax       = (smp.touch_x >= prev_x) ? dx : (prev_x - smp.touch_x);
    ay       = (smp.touch_y >= prev_y) ? dy : (prev_y - smp.touch_y);
    sx       = scale8(dx, smp.speed_fast, smp.speed_slow);
    sy       = scale8(dy, smp.speed_fast, smp.speed_slow);
    sum_wide = {2'b00, motion_sum} + {10'd0, ax} + {10'd0, ay};
    sum_sat  = (sum_wide > {2'b00, ttrm_pkg::Sat16}) ? ttrm_pkg::Sat16 : sum_wide[15:0];

    // motion sum and hold check happen only while the touch continues
    motion_sum_next   = moving ? sum_sat : motion_sum;
    hold_now          = moving && (sample_count > cfg.hold_count_min)
                        && (sum_sat < cfg.hold_motion_max);
    hold_latched_next = hold_latched | hold_now;

    tap = !smp.touch_down && was_touching
          && (motion_sum < cfg.tap_motion_max) && (sample_count < cfg.tap_count_max);

    rpt.mouse_buttons[0] = tap || hold_latched_next
                           || ((smp.button_keys & ttrm_pkg::LeftKeys) != 8'd0);
    rpt.mouse_buttons[1] = (smp.button_keys & ttrm_pkg::RightKeys) != 8'd0;
    rpt.delta_x          = moving ? sx : 8'sd0;
    rpt.delta_y          = moving ? sy : 8'sd0;

    if (smp.touch_down) begin
      sample_count_next = (sample_count != ttrm_pkg::Sat16) ? sample_count + 16'd1
                                                            : sample_count;
      was_touching_next = 1'b1;
      prev_x_next       = smp.touch_x;
      prev_y_next       = smp.touch_y;
    end else begin
      sample_count_next = 16'd0;
      was_touching_next = 1'b0;
      prev_x_next       = 8'd0;
      prev_y_next       = 8'd0;
      motion_sum_next   = 16'd0;
      hold_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_touching <= 1'b0;
      prev_x       <= 8'd0;
      prev_y       <= 8'd0;
      sample_count <= 16'd0;
      motion_sum   <= 16'd0;
      hold_latched <= 1'b0;
    end else if (fire) begin
      was_touching <= was_touching_next;
      prev_x       <= prev_x_next;
      prev_y       <= prev_y_next;
      sample_count <= sample_count_next;
      motion_sum   <= motion_sum_next;
      hold_latched <= hold_latched_next;
    end
  end

endmodule

@@ rtl/touch_to_relative_mouse.sv @@
// ----------------------------------------------------------------------------
// touch_to_relative_mouse
// turns absolute touch panel samples and key states into relative mouse reports
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid / in_stall  | touch sample and key states
//   out     | output    | out_valid / out_stall| buttons, delta_x, delta_y
//   cfg     | input     | cfg_we               | cfg_index, cfg_data (write only)
//
// one word in, one word out; an accepted word sits in the input register and
// moves into the output register once that register is empty or being
// drained; one word per cycle is sustained while out_stall is low, set by the
// input register, the single update of the tracking state and the result
// register; rst clears the tracking state and both valid flags and loads the
// default thresholds; out_stall holds the result register; the input register
// then fills and in_stall rises until the result is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_to_relative_mouse_defines.svh"

module touch_to_relative_mouse (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         touch_down,
  input  logic [7:0]                   touch_x,
  input  logic [7:0]                   touch_y,
  input  logic                         speed_fast,
  input  logic                         speed_slow,
  input  logic [7:0]                   button_keys,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   mouse_buttons,
  output logic signed [7:0]            delta_x,
  output logic signed [7:0]            delta_y,

  input  logic                         cfg_we,
  input  logic [ttrm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);

  ttrm_pkg::cfg_t    cfg;
  ttrm_pkg::sample_t s1;       // input register payload
  logic              s1_valid;
  ttrm_pkg::report_t rpt;      // report computed from s1
  ttrm_pkg::report_t res;      // result register
  logic              fire;     // s1 word moves into the result register
  logic              in_take;

  // result register can load when empty or being drained this cycle
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  ttrm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttrm_track u_track (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .smp  (s1),
    .rpt  (rpt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1.touch_down  <= touch_down;
      s1.touch_x     <= touch_x;
      s1.touch_y     <= touch_y;
      s1.speed_fast  <= speed_fast;
      s1.speed_slow  <= speed_slow;
      s1.button_keys <= button_keys;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= rpt;
    end
  end

  assign mouse_buttons = res.mouse_buttons;
  assign delta_x       = res.delta_x;
  assign delta_y       = res.delta_y;

  // assertions
  `TTRM_ASSERT_ALWAYS(a_rst_empty, rst |=> (!s1_valid && !out_valid), "valid after reset")
  `TTRM_ASSERT(a_take_fills, in_take |=> s1_valid, "accepted word lost from input register")
  `TTRM_ASSERT(a_fire_loads, fire |=> out_valid, "fired word missing from result register")
  `TTRM_ASSERT(a_release_still, (fire && !s1.touch_down) |=> (delta_x == 8'sd0 && delta_y == 8'sd0), "motion reported without touch")

endmodule
